/* hw/rtl/element_frequency_counter_defines.svh */
`ifndef ELEMENT_FREQUENCY_COUNTER_DEFINES_SVH
`define ELEMENT_FREQUENCY_COUNTER_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define EFC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("efc check failed");

// Next-cycle implication, sampled on clk_i, off during reset.
`define EFC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("efc check failed");

`endif

/* hw/rtl/efc_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package efc_pkg;

  localparam int unsigned TABLE_DEPTH = 64;
  localparam int unsigned COUNT_WIDTH = 16;

  localparam int unsigned ELEM_W = 32;
  localparam int unsigned FREQ_W = 16;
  localparam int unsigned USED_W = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned EXT_W  = COUNT_WIDTH + FREQ_W;

  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;
  localparam logic [FREQ_W-1:0]      FREQ_MAX  = '1;

  typedef struct packed {
    logic [ELEM_W-1:0] element;
    logic              end_of_set;
  } in_word_t;

  typedef struct packed {
    logic [ELEM_W-1:0] value;
    logic [FREQ_W-1:0] frequency;
    logic              final_entry;
    logic              overflowed;
  } out_word_t;

  typedef struct packed {
    logic take;   // accept element into table
    logic shift;  // pop head entry
  } dp_cmd_t;

  typedef struct packed {
    logic [USED_W-1:0] used;
    logic              last;  // exactly one entry left
  } dp_status_t;

  typedef enum logic {
    ST_COLLECT,
    ST_DRAIN
  } state_e;

endpackage

`default_nettype wire

/* hw/rtl/efc_stream_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface efc_in_if;
  logic              valid;
  logic              ready;
  efc_pkg::in_word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface efc_out_if;
  logic               valid;
  logic               ready;
  efc_pkg::out_word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

/* hw/rtl/efc_datapath.sv */
`timescale 1ns / 1ps
`default_nettype none

module efc_datapath (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire efc_pkg::in_word_t   in_word_i,
  input  wire efc_pkg::dp_cmd_t    cmd_i,
  output efc_pkg::out_word_t       out_word_o,
  output efc_pkg::dp_status_t      status_o
);

  localparam int unsigned D  = efc_pkg::TABLE_DEPTH;
  localparam int unsigned CW = efc_pkg::COUNT_WIDTH;
  localparam int unsigned UW = efc_pkg::USED_W;

  logic [efc_pkg::ELEM_W-1:0] val_q [D];
  logic [CW-1:0]              cnt_q [D];
  logic [efc_pkg::ELEM_W-1:0] val_d [D];
  logic [CW-1:0]              cnt_d [D];
  logic [UW-1:0]              used_q, used_d;
  logic                       ovf_q, ovf_d;

  logic [D-1:0] vld;
  logic [D-1:0] hit;
  logic         any_hit;
  logic         room;
  logic [efc_pkg::EXT_W-1:0] cnt_ext;

  // per-cell valid and match
  always_comb begin
    for (int i = 0; i < D; i++) begin
      vld[i] = (UW'(i) < used_q);
      hit[i] = vld[i] && (val_q[i] == in_word_i.element);
    end
  end

  assign any_hit = |hit;
  assign room    = (used_q != UW'(D));

  always_comb begin
    used_d = used_q;
    ovf_d  = ovf_q;
    for (int i = 0; i < D; i++) begin
      val_d[i] = val_q[i];
      cnt_d[i] = cnt_q[i];
    end
    if (cmd_i.take) begin
      if (any_hit) begin
        for (int i = 0; i < D; i++) begin
          if (hit[i] && (cnt_q[i] != efc_pkg::COUNT_MAX)) begin
            cnt_d[i] = cnt_q[i] + CW'(1);
          end
        end
      end else if (room) begin
        for (int i = 0; i < D; i++) begin
          if (UW'(i) == used_q) begin
            val_d[i] = in_word_i.element;
            cnt_d[i] = CW'(1);
          end
        end
        used_d = used_q + UW'(1);
      end else begin
        ovf_d = 1'b1;
      end
    end else if (cmd_i.shift) begin
      for (int i = 0; i < D - 1; i++) begin
        val_d[i] = val_q[i+1];
        cnt_d[i] = cnt_q[i+1];
      end
      used_d = used_q - UW'(1);
      if (used_q == UW'(1)) begin
        ovf_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < D; i++) begin
      val_q[i] <= val_d[i];
      cnt_q[i] <= cnt_d[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= '0;
      ovf_q  <= 1'b0;
    end else begin
      used_q <= used_d;
      ovf_q  <= ovf_d;
    end
  end

  // head cell drives the result word
  assign cnt_ext = {{efc_pkg::FREQ_W{1'b0}}, cnt_q[0]};

  always_comb begin
    out_word_o.value       = val_q[0];
    out_word_o.frequency   = (cnt_ext > efc_pkg::EXT_W'(efc_pkg::FREQ_MAX)) ?
                             efc_pkg::FREQ_MAX : cnt_ext[efc_pkg::FREQ_W-1:0];
    out_word_o.final_entry = (used_q == UW'(1));
    out_word_o.overflowed  = ovf_q;
  end

  assign status_o.used = used_q;
  assign status_o.last = (used_q == UW'(1));

endmodule

`default_nettype wire

/* hw/rtl/efc_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none

module efc_ctrl (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  input  wire logic                in_end_i,
  output logic                     in_ready_o,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  input  wire efc_pkg::dp_status_t status_i,
  output efc_pkg::dp_cmd_t         cmd_o
);

  efc_pkg::state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      efc_pkg::ST_COLLECT: begin
        if (in_valid_i && in_end_i) begin
          state_d = efc_pkg::ST_DRAIN;
        end
      end
      efc_pkg::ST_DRAIN: begin
        if (out_ready_i && status_i.last) begin
          state_d = efc_pkg::ST_COLLECT;
        end
      end
      default: state_d = efc_pkg::ST_COLLECT;
    endcase
  end

  always_comb begin
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    cmd_o       = '0;
    unique case (state_q)
      efc_pkg::ST_COLLECT: begin
        in_ready_o = 1'b1;
        cmd_o.take = in_valid_i;
      end
      efc_pkg::ST_DRAIN: begin
        out_valid_o = 1'b1;
        cmd_o.shift = out_ready_i;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= efc_pkg::ST_COLLECT;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/element_frequency_counter.sv */
// The first result word is offered in the cycle after the word carrying end_of_set is taken.
// Throughput: one element per cycle while collecting; every table cell compares in parallel.
// Drain: n result words for n table entries, one per cycle while out_o is ready;
// no element is taken during the drain.
// Reset: clears the entry count, the overflow flag and the controller; cell contents
// are left undefined and are never read before being written.
`timescale 1ns / 1ps
`default_nettype none
`include "element_frequency_counter_defines.svh"

module element_frequency_counter (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  efc_in_if.sink    in_i,
  efc_out_if.source out_o
);

  efc_pkg::dp_cmd_t    cmd;
  efc_pkg::dp_status_t status;
  efc_pkg::out_word_t  out_word;
  logic                in_ready;
  logic                out_valid;
  logic                end_fire;
  logic                out_fire;

  efc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_end_i    (in_i.data.end_of_set),
    .in_ready_o  (in_ready),
    .out_valid_o (out_valid),
    .out_ready_i (out_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  efc_datapath u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_word_i  (in_i.data),
    .cmd_i      (cmd),
    .out_word_o (out_word),
    .status_o   (status)
  );

  assign in_i.ready  = in_ready;
  assign out_o.valid = out_valid;
  assign out_o.data  = out_word;

  assign end_fire = in_i.valid && in_ready && in_i.data.end_of_set;
  assign out_fire = out_valid && out_o.ready;

  `EFC_ASSERT_NOW(a_no_overlap, out_valid, !in_ready)
  `EFC_ASSERT_NOW(a_drain_nonempty, out_valid, status.used != '0)
  `EFC_ASSERT_NEXT(a_end_starts_drain, end_fire, out_valid)
  `EFC_ASSERT_NEXT(a_final_clears, out_fire && out_word.final_entry, status.used == '0 && !out_valid)

endmodule

`default_nettype wire
